>>> hdl/rv32ie_pkg.sv
// Package for the RV32I execute block: opcodes, sizes and the execute result type.
package rv32ie_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int MEM_ROWS  = MEM_BYTES / 4;
    localparam int ROW_W     = $clog2(MEM_ROWS);
    localparam int XLEN      = 32;

    typedef enum logic [5:0] {
        OP_LUI   = 6'd0,  OP_AUIPC = 6'd1,  OP_JAL   = 6'd2,  OP_JALR  = 6'd3,
        OP_BEQ   = 6'd4,  OP_BNE   = 6'd5,  OP_BLT   = 6'd6,  OP_BGE   = 6'd7,
        OP_BLTU  = 6'd8,  OP_BGEU  = 6'd9,  OP_LB    = 6'd10, OP_LH    = 6'd11,
        OP_LW    = 6'd12, OP_LBU   = 6'd13, OP_LHU   = 6'd14, OP_SB    = 6'd15,
        OP_SH    = 6'd16, OP_SW    = 6'd17, OP_ADDI  = 6'd18, OP_SLTI  = 6'd19,
        OP_SLTIU = 6'd20, OP_XORI  = 6'd21, OP_ORI   = 6'd22, OP_ANDI  = 6'd23,
        OP_SLLI  = 6'd24, OP_SRLI  = 6'd25, OP_SRAI  = 6'd26, OP_ADD   = 6'd27,
        OP_SUB   = 6'd28, OP_SLL   = 6'd29, OP_SLT   = 6'd30, OP_SLTU  = 6'd31,
        OP_XOR   = 6'd32, OP_SRL   = 6'd33, OP_SRA   = 6'd34, OP_OR    = 6'd35,
        OP_AND   = 6'd36
    } t_op;

    // memory access width in bytes, minus one
    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_HALF = 2'd1,
        SZ_WORD = 2'd3
    } t_size;

    typedef struct packed {
        logic [XLEN-1:0] next_pc;
        logic            wr;
        logic [XLEN-1:0] val;
        logic            br;
        logic            st;
        logic            ld;
        logic            ld_signed;
        t_size           size;
        logic [XLEN-1:0] addr;
    } t_ex;

endpackage

>>> hdl/rv32ie_ram.sv
// Generic single-clock RAM with one write port and a registered read port.
module rv32ie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> hdl/rv32ie_alu.sv
// Execute logic: ALU, branch compare, address and next pc for one instruction.
module rv32ie_alu (
    input  logic [5:0]                i_op,
    input  logic [rv32ie_pkg::XLEN-1:0] i_pc,
    input  logic [rv32ie_pkg::XLEN-1:0] i_a,
    input  logic [rv32ie_pkg::XLEN-1:0] i_b,
    input  logic [rv32ie_pkg::XLEN-1:0] i_imm,
    output rv32ie_pkg::t_ex           o_ex
);
    import rv32ie_pkg::*;

    logic [XLEN-1:0] sum;
    logic [XLEN-1:0] pc4;
    logic [XLEN-1:0] pc_imm;
    logic            lts;
    logic            ltu;
    logic            lts_i;
    logic            ltu_i;
    logic            cond;

    always_comb begin
        sum    = i_a + i_imm;
        pc4    = i_pc + 32'd4;
        pc_imm = i_pc + i_imm;
        lts    = $signed(i_a) < $signed(i_b);
        ltu    = i_a < i_b;
        lts_i  = $signed(i_a) < $signed(i_imm);
        ltu_i  = i_a < i_imm;
        cond   = 1'b0;

        o_ex           = '0;
        o_ex.next_pc   = pc4;
        o_ex.addr      = sum;
        o_ex.size      = SZ_BYTE;

        case (t_op'(i_op))
            OP_LUI:   begin o_ex.wr = 1'b1; o_ex.val = i_imm << 12; end
            OP_AUIPC: begin o_ex.wr = 1'b1; o_ex.val = i_pc + (i_imm << 12); end
            OP_JAL: begin
                o_ex.wr = 1'b1; o_ex.val = pc4; o_ex.next_pc = pc_imm; o_ex.br = 1'b1;
            end
            OP_JALR: begin
                o_ex.wr = 1'b1; o_ex.val = pc4; o_ex.br = 1'b1;
                o_ex.next_pc = {sum[XLEN-1:1], 1'b0};
            end
            OP_BEQ:   cond = (i_a == i_b);
            OP_BNE:   cond = (i_a != i_b);
            OP_BLT:   cond = lts;
            OP_BGE:   cond = !lts;
            OP_BLTU:  cond = ltu;
            OP_BGEU:  cond = !ltu;
            OP_LB:    begin o_ex.wr = 1'b1; o_ex.ld = 1'b1; o_ex.ld_signed = 1'b1; end
            OP_LH: begin
                o_ex.wr = 1'b1; o_ex.ld = 1'b1; o_ex.ld_signed = 1'b1; o_ex.size = SZ_HALF;
            end
            OP_LW:    begin o_ex.wr = 1'b1; o_ex.ld = 1'b1; o_ex.size = SZ_WORD; end
            OP_LBU:   begin o_ex.wr = 1'b1; o_ex.ld = 1'b1; end
            OP_LHU:   begin o_ex.wr = 1'b1; o_ex.ld = 1'b1; o_ex.size = SZ_HALF; end
            OP_SB:    o_ex.st = 1'b1;
            OP_SH:    begin o_ex.st = 1'b1; o_ex.size = SZ_HALF; end
            OP_SW:    begin o_ex.st = 1'b1; o_ex.size = SZ_WORD; end
            OP_ADDI:  begin o_ex.wr = 1'b1; o_ex.val = sum; end
            OP_SLTI:  begin o_ex.wr = 1'b1; o_ex.val = {31'd0, lts_i}; end
            OP_SLTIU: begin o_ex.wr = 1'b1; o_ex.val = {31'd0, ltu_i}; end
            OP_XORI:  begin o_ex.wr = 1'b1; o_ex.val = i_a ^ i_imm; end
            OP_ORI:   begin o_ex.wr = 1'b1; o_ex.val = i_a | i_imm; end
            OP_ANDI:  begin o_ex.wr = 1'b1; o_ex.val = i_a & i_imm; end
            OP_SLLI:  begin o_ex.wr = 1'b1; o_ex.val = i_a << i_imm[4:0]; end
            OP_SRLI:  begin o_ex.wr = 1'b1; o_ex.val = i_a >> i_imm[4:0]; end
            OP_SRAI: begin
                o_ex.wr = 1'b1; o_ex.val = XLEN'($signed(i_a) >>> i_imm[4:0]);
            end
            OP_ADD:   begin o_ex.wr = 1'b1; o_ex.val = i_a + i_b; end
            OP_SUB:   begin o_ex.wr = 1'b1; o_ex.val = i_a - i_b; end
            OP_SLL:   begin o_ex.wr = 1'b1; o_ex.val = i_a << i_b[4:0]; end
            OP_SLT:   begin o_ex.wr = 1'b1; o_ex.val = {31'd0, lts}; end
            OP_SLTU:  begin o_ex.wr = 1'b1; o_ex.val = {31'd0, ltu}; end
            OP_XOR:   begin o_ex.wr = 1'b1; o_ex.val = i_a ^ i_b; end
            OP_SRL:   begin o_ex.wr = 1'b1; o_ex.val = i_a >> i_b[4:0]; end
            OP_SRA: begin
                o_ex.wr = 1'b1; o_ex.val = XLEN'($signed(i_a) >>> i_b[4:0]);
            end
            OP_OR:    begin o_ex.wr = 1'b1; o_ex.val = i_a | i_b; end
            OP_AND:   begin o_ex.wr = 1'b1; o_ex.val = i_a & i_b; end
            default:  ;
        endcase

        if (cond) begin
            o_ex.next_pc = pc_imm;
            o_ex.br      = 1'b1;
        end
    end
endmodule

>>> hdl/rv32i_instruction_execute.sv
// Top level of the RV32I execute block: register file, data memory and pipeline control.
//
//  channel  dir  handshake           word
//  input    in   i_valid / o_stall   op, dest/src indexes, immediate
//  result   out  o_valid / i_stall   next pc, register write, branch and store flags
//
// One instruction per cycle sustained while the output is not stalled; a result passes through
// the register read, then execute and memory access, then the output register.
// Register and load results are forwarded from the output register and from the write
// that coincides with the register read, so dependent words issue back to back.
// After reset a clearing pass zeroes data memory and the register file; o_stall is high
// during it. A stalled output holds the output register, and a full stage 1 raises o_stall.
module rv32i_instruction_execute (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [5:0]  i_op,
    input  logic [4:0]  i_dest_index,
    input  logic [4:0]  i_src1_index,
    input  logic [4:0]  i_src2_index,
    input  logic [31:0] i_immediate,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_next_pc,
    output logic        o_reg_written,
    output logic [4:0]  o_written_index,
    output logic [31:0] o_written_value,
    output logic        o_took_branch,
    output logic        o_did_store
);
    import rv32ie_pkg::*;

    // control
    logic             r_clearing;
    logic [ROW_W-1:0] r_clr_row;
    logic             in_acc;
    logic             out_acc;
    logic             s1_adv;
    logic             s1_go;

    // stage 1
    logic             r_s1_valid;
    logic [5:0]       r_s1_op;
    logic [4:0]       r_s1_rd;
    logic [4:0]       r_s1_rs1;
    logic [4:0]       r_s1_rs2;
    logic [XLEN-1:0]  r_s1_imm;
    logic             r_byp_en;
    logic [4:0]       r_byp_idx;
    logic [XLEN-1:0]  r_byp_val;
    logic [XLEN-1:0]  r_pc;

    // stage 2 / output
    logic             r_s2_valid;
    logic [XLEN-1:0]  r_s2_next_pc;
    logic             r_s2_wr;
    logic [4:0]       r_s2_idx;
    logic [XLEN-1:0]  r_s2_val;
    logic             r_s2_br;
    logic             r_s2_st;
    logic             r_s2_ld;
    logic             r_s2_ld_signed;
    t_size            r_s2_size;
    logic [1:0]       r_s2_lo;

    logic [XLEN-1:0]  rf_a;
    logic [XLEN-1:0]  rf_b;
    logic [XLEN-1:0]  op_a;
    logic [XLEN-1:0]  op_b;
    logic [XLEN-1:0]  s2_value;
    logic [XLEN-1:0]  ld_raw;
    logic [XLEN-1:0]  ld_val;
    logic             rf_we;
    logic [4:0]       rf_waddr;
    logic [XLEN-1:0]  rf_wdata;
    t_ex              ex;

    logic [7:0]       lane_rdata [4];
    logic [7:0]       lane_wdata [4];
    logic [ROW_W-1:0] lane_addr  [4];
    logic             lane_we    [4];
    logic             lane_re;
    logic [1:0]       lane_k;
    logic [ROW_W-1:0] a_row;
    logic [1:0]       a_lo;

    assign out_acc = r_s2_valid & ~i_stall;
    assign s1_adv  = ~r_s2_valid | out_acc;
    assign s1_go   = r_s1_valid & s1_adv;
    assign o_stall = r_clearing | (r_s1_valid & ~s1_adv);
    assign in_acc  = i_valid & ~o_stall;

    // register file: two copies, one per read port
    always_comb begin
        if (r_clearing) begin
            rf_we    = (r_clr_row < ROW_W'(32));
            rf_waddr = r_clr_row[4:0];
            rf_wdata = '0;
        end else begin
            rf_we    = out_acc & r_s2_wr;
            rf_waddr = r_s2_idx;
            rf_wdata = s2_value;
        end
    end

    rv32ie_ram #(.WIDTH(XLEN), .DEPTH(32)) u_rf_a (
        .i_clk(i_clk), .i_we(rf_we), .i_waddr(rf_waddr), .i_wdata(rf_wdata),
        .i_re(in_acc), .i_raddr(i_src1_index), .o_rdata(rf_a)
    );
    rv32ie_ram #(.WIDTH(XLEN), .DEPTH(32)) u_rf_b (
        .i_clk(i_clk), .i_we(rf_we), .i_waddr(rf_waddr), .i_wdata(rf_wdata),
        .i_re(in_acc), .i_raddr(i_src2_index), .o_rdata(rf_b)
    );

    // operand forwarding: output register first, then the write seen at read time
    always_comb begin
        if (r_s2_valid && r_s2_wr && r_s2_idx == r_s1_rs1) begin
            op_a = s2_value;
        end else if (r_byp_en && r_byp_idx == r_s1_rs1) begin
            op_a = r_byp_val;
        end else begin
            op_a = rf_a;
        end
        if (r_s2_valid && r_s2_wr && r_s2_idx == r_s1_rs2) begin
            op_b = s2_value;
        end else if (r_byp_en && r_byp_idx == r_s1_rs2) begin
            op_b = r_byp_val;
        end else begin
            op_b = rf_b;
        end
    end

    rv32ie_alu u_alu (
        .i_op(r_s1_op), .i_pc(r_pc), .i_a(op_a), .i_b(op_b), .i_imm(r_s1_imm), .o_ex(ex)
    );

    // data memory: four byte lanes, byte address a lives in lane a[1:0], row a[..:2]
    assign a_row   = ex.addr[ROW_W+1:2];
    assign a_lo    = ex.addr[1:0];
    assign lane_re = s1_go & ex.ld;

    always_comb begin
        lane_k = '0;
        for (int l = 0; l < 4; l++) begin
            lane_k = 2'(l) - a_lo;
            if (r_clearing) begin
                lane_addr[l]  = r_clr_row;
                lane_we[l]    = 1'b1;
                lane_wdata[l] = '0;
            end else begin
                lane_addr[l]  = a_row + ROW_W'(2'(l) < a_lo);
                lane_we[l]    = s1_go & ex.st & (lane_k <= ex.size);
                lane_wdata[l] = op_b[8*lane_k +: 8];
            end
        end
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
        rv32ie_ram #(.WIDTH(8), .DEPTH(MEM_ROWS)) u_mem (
            .i_clk(i_clk), .i_we(lane_we[l]), .i_waddr(lane_addr[l]),
            .i_wdata(lane_wdata[l]), .i_re(lane_re), .i_raddr(lane_addr[l]),
            .o_rdata(lane_rdata[l])
        );
    end

    // load alignment and extension
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            ld_raw[8*k +: 8] = lane_rdata[2'(k) + r_s2_lo];
        end
        case (r_s2_size)
            SZ_BYTE: ld_val = {{24{r_s2_ld_signed & ld_raw[7]}}, ld_raw[7:0]};
            SZ_HALF: ld_val = {{16{r_s2_ld_signed & ld_raw[15]}}, ld_raw[15:0]};
            default: ld_val = ld_raw;
        endcase
        s2_value = r_s2_ld ? ld_val : r_s2_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_row  <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_pc       <= '0;
            r_byp_en   <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_row <= r_clr_row + 1'b1;
                if (r_clr_row == ROW_W'(MEM_ROWS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            r_s1_valid <= in_acc | (r_s1_valid & ~s1_adv);
            if (s1_adv) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s1_go) begin
                r_pc <= ex.next_pc;
            end
            if (in_acc) begin
                r_byp_en <= rf_we;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op   <= i_op;
            r_s1_rd   <= i_dest_index;
            r_s1_rs1  <= i_src1_index;
            r_s1_rs2  <= i_src2_index;
            r_s1_imm  <= i_immediate;
            r_byp_idx <= rf_waddr;
            r_byp_val <= rf_wdata;
        end
        if (s1_go) begin
            r_s2_next_pc   <= ex.next_pc;
            r_s2_wr        <= ex.wr & (r_s1_rd != 5'd0);
            r_s2_idx       <= (ex.wr && r_s1_rd != 5'd0) ? r_s1_rd : 5'd0;
            r_s2_val       <= ex.val;
            r_s2_br        <= ex.br;
            r_s2_st        <= ex.st;
            r_s2_ld        <= ex.ld;
            r_s2_ld_signed <= ex.ld_signed;
            r_s2_size      <= ex.size;
            r_s2_lo        <= a_lo;
        end
    end

    assign o_valid         = r_s2_valid;
    assign o_next_pc       = r_s2_next_pc;
    assign o_reg_written   = r_s2_wr;
    assign o_written_index = r_s2_idx;
    assign o_written_value = r_s2_wr ? s2_value : '0;
    assign o_took_branch   = r_s2_br;
    assign o_did_store     = r_s2_st;
endmodule
